// ===== rtl/wma_pkg.sv =====
`default_nettype none

package wma_pkg;

    // Sample and result width (signed Q16.16).
    localparam int SAMPLE_W = 32;

    // Period register width and its value after reset.
    localparam int PERIOD_W = 7;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd20;

    // Running sum of up to 127 samples.
    localparam int TSUM_W = SAMPLE_W + PERIOD_W;

    // Weighted sum: 127 running sums of TSUM_W bits.
    localparam int WSUM_W = TSUM_W + PERIOD_W;

    // Normaliser p*(p+1)/2 for p up to 127.
    localparam int NORM_W = 13;

endpackage

`default_nettype wire

// ===== rtl/wma_window_ram.sv =====
`default_nettype none

module wma_window_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire                              i_clk,
    input  wire                              i_we,
    input  wire  [ADDR_W-1:0]                i_waddr,
    input  wire  [wma_pkg::SAMPLE_W-1:0]     i_wdata,
    input  wire  [ADDR_W-1:0]                i_raddr,
    output logic [wma_pkg::SAMPLE_W-1:0]     o_rdata
);

    logic [wma_pkg::SAMPLE_W-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/wma_div.sv =====
`default_nettype none

module wma_div (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_start,
    input  wire  signed [wma_pkg::WSUM_W-1:0]     i_dividend,
    input  wire  [wma_pkg::NORM_W-1:0]            i_divisor,
    output logic                                  o_done,
    output logic [wma_pkg::SAMPLE_W-1:0]          o_quotient
);

    localparam int DW = wma_pkg::WSUM_W;
    localparam int NW = wma_pkg::NORM_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_rem;
    logic [DW-1:0]    r_q;
    logic [NW-1:0]    r_div;
    logic             r_neg;

    logic [NW:0] w_shift;
    logic [NW:0] w_diff;

    // Shift the next dividend bit into the remainder and trial-subtract.
    assign w_shift = {r_rem, r_q[DW-1]};
    assign w_diff  = w_shift - {1'b0, r_div};

    // Restoring division on magnitudes, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_neg  <= i_dividend[DW-1];
                r_q    <= i_dividend[DW-1] ? DW'(-i_dividend) : DW'(i_dividend);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy     <= 1'b0;
                    o_done     <= 1'b1;
                    o_quotient <= r_neg ? (-r_q[wma_pkg::SAMPLE_W-1:0])
                                        : r_q[wma_pkg::SAMPLE_W-1:0];
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                    if (!w_diff[NW]) begin
                        r_rem <= w_diff[NW-1:0];
                        r_q   <= {r_q[DW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_shift[NW-1:0];
                        r_q   <= {r_q[DW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // The quotient is only ever reported at the end of a division.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("divider finished without running");

endmodule

`default_nettype wire

// ===== rtl/weighted_moving_average.sv =====
`default_nettype none

// Linear weighted moving average over signed Q16.16 samples.
// A beat is taken only in the idle state, so a new sample waits until the last result has been
// handed to the output. Each beat goes through p reads, the read drain, a 46-step divider plus
// its load and finish steps, and the hand-over to the output; an incomplete window goes straight to the output.
// Reset sets the period to 20 and clears the write pointer and the sample count; the window
// is not cleared, and an entry is only read after it has been written.
module weighted_moving_average #(
    parameter int MAX_WINDOW = 64
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Configuration: period register
    input  wire                                i_cfg_we,
    input  wire  [wma_pkg::PERIOD_W-1:0]       i_cfg_wdata,
    // Input stream
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [31:0]                        s_axis_tdata,   // [31:0] sample
    // Output stream
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [31:0]                        m_axis_tdata,   // [31:0] average
    output logic [0:0]                         m_axis_tuser    // [0] valid_res
);

    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int SEEN_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (SEEN_W > wma_pkg::PERIOD_W) ? SEEN_W : wma_pkg::PERIOD_W;
    localparam int PW     = wma_pkg::PERIOD_W;
    localparam int TW     = wma_pkg::TSUM_W;
    localparam int SW     = wma_pkg::WSUM_W;
    localparam int NW     = wma_pkg::NORM_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV,
        ST_PUT
    } t_state;

    t_state r_state;

    logic [PW-1:0]     r_period;
    logic [ADDR_W-1:0] r_wp;
    logic [SEEN_W-1:0] r_seen;
    logic [PW-1:0]     r_p;
    logic [NW-1:0]     r_norm;
    logic [ADDR_W-1:0] r_slot;
    logic [PW-1:0]     r_issue;
    logic              r_rvld;
    logic signed [TW-1:0] r_t;
    logic signed [SW-1:0] r_s;
    logic              r_div_start;
    logic [31:0]       r_res_avg;
    logic              r_res_vld;

    logic              w_accept;
    logic [31:0]       w_rdata;
    logic [SEEN_W-1:0] w_seen_next;
    logic              w_valid;
    logic [2*PW-1:0]   w_prod;
    logic signed [TW-1:0] n_t;
    logic signed [SW-1:0] n_s;
    logic              w_div_done;
    logic [31:0]       w_quot;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Sample count after this beat, saturating at the window depth.
    assign w_seen_next = (r_seen == SEEN_W'(MAX_WINDOW)) ? r_seen : r_seen + 1'b1;
    assign w_valid     = (r_period != '0) && (CMP_W'(r_period) <= CMP_W'(w_seen_next));

    // Normaliser p*(p+1)/2.
    assign w_prod = (2*PW)'(r_period) * ((2*PW)'(r_period) + 1'b1);

    // The weighted sum is the sum of running sums taken newest first.
    assign n_t = r_t + {{(TW-32){w_rdata[31]}}, w_rdata};
    assign n_s = r_s + {{(SW-TW){n_t[TW-1]}}, n_t};

    wma_window_ram #(
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_wp),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    wma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_s),
        .i_divisor  (r_norm),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Period register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= wma_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    // Sequencer: store the sample, walk the window and divide if it is valid, present the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_wp          <= '0;
            r_seen        <= '0;
            r_rvld        <= 1'b0;
            r_div_start   <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            // The output state reloads the beat itself when the sink takes the old one.
            if (m_axis_tvalid && m_axis_tready && (r_state != ST_PUT)) begin
                m_axis_tvalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_wp    <= (r_wp == ADDR_W'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
                        r_seen  <= w_seen_next;
                        r_p     <= r_period;
                        r_norm  <= w_prod[NW:1];
                        r_slot  <= r_wp;
                        r_issue <= '0;
                        r_rvld  <= 1'b0;
                        r_t     <= '0;
                        r_s     <= '0;
                        if (w_valid) begin
                            r_state <= ST_RUN;
                        end else begin
                            r_res_avg <= '0;
                            r_res_vld <= 1'b0;
                            r_state   <= ST_PUT;
                        end
                    end
                end
                ST_RUN: begin
                    if (r_issue != r_p) begin
                        r_issue <= r_issue + 1'b1;
                        r_slot  <= (r_slot == '0) ? ADDR_W'(MAX_WINDOW - 1) : r_slot - 1'b1;
                        r_rvld  <= 1'b1;
                    end else begin
                        r_rvld <= 1'b0;
                    end
                    if (r_rvld) begin
                        r_t <= n_t;
                        r_s <= n_s;
                    end
                    if ((r_issue == r_p) && !r_rvld) begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_res_avg <= w_quot;
                        r_res_vld <= 1'b1;
                        r_state   <= ST_PUT;
                    end
                end
                ST_PUT: begin
                    if (!m_axis_tvalid || m_axis_tready) begin
                        m_axis_tvalid   <= 1'b1;
                        m_axis_tdata    <= r_res_avg;
                        m_axis_tuser[0] <= r_res_vld;
                        r_state         <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // An incomplete window always reports a zero average.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("average not zero on an invalid result");

    // The sample count saturates at the window depth.
    a_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_W'(MAX_WINDOW))
        else $error("sample count beyond window depth");

    // The walk never reads more entries than the period.
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_issue <= r_p)
        else $error("window walk overran the period");

    // The divider only completes while the sequencer waits for it.
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV)
        else $error("division finished outside the divide state");

endmodule

`default_nettype wire
